[sv/kmau_pkg.sv]
// ----------------------------------------------------------------------------
// kmau_pkg
// Shared types and constants for the k-means assign/update core.
// ----------------------------------------------------------------------------
package kmau_pkg;

  localparam int FEAT_W = 16;
  localparam int SUM_W  = 36;
  localparam int SQ_W   = 32;
  localparam int DIV_STEPS = SUM_W;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_VECTOR = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_V_RD,
    ST_V_SQ,
    ST_V_ACC,
    ST_A_RD,
    ST_A_ADD,
    ST_C_RD,
    ST_C_WR,
    ST_U_CNT,
    ST_U_N,
    ST_U_RD,
    ST_U_LD,
    ST_U_DIV,
    ST_U_WR,
    ST_EMIT
  } state_t;

endpackage

[sv/kmau_ram.sv]
// ----------------------------------------------------------------------------
// kmau_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kmau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/kmeans_assign_and_update_core.sv]
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_core
// One Lloyd iteration of k-means, run element by element.
// ----------------------------------------------------------------------------
// Holds CLUSTERS centers of DIM unsigned Q0.16 features in RAM. Load words
// write one center element. A vector element word walks all centers through
// one shared abs-difference/square/accumulate unit (V_RD, V_SQ, V_ACC per
// center); the last element of a vector then adds the element sums (A_RD,
// A_ADD) and the count (C_RD, C_WR) unless MAX_VECTORS vectors were already
// counted, then the result is emitted. An update word runs one 36-step
// restoring divider per center element of a non-empty cluster and writes zero
// for empty ones. After reset the block clears the sum RAM before in_ready
// rises. A finished result waits in the output register; in_ready is high
// only while the sequencer is idle.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update_core #(
  parameter int DIM         = 16,
  parameter int CLUSTERS    = 16,
  parameter int MAX_VECTORS = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_cluster_index,
  input  logic [3:0]  in_dim_index,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_class_index,
  output logic [35:0] out_min_sq_distance,
  output logic        out_update_done,
  output logic        out_pass_overflow
);
  import kmau_pkg::*;

  localparam int N    = CLUSTERS * DIM;
  localparam int NW   = (N > 1) ? $clog2(N) : 1;
  localparam int DW   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KW   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int CNTW = $clog2(MAX_VECTORS + 1);
  localparam int STW  = $clog2(DIV_STEPS);
  localparam logic [SUM_W-1:0] SAT = '1;

  state_t state_r, state_nxt;

  logic [DW-1:0]     e_r, e_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  logic [KW-1:0]     c_r, c_nxt;
  logic [NW-1:0]     addr_r, addr_nxt;
  logic [NW-1:0]     base_r, base_nxt;
  logic [FEAT_W-1:0] val_r, val_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [KW-1:0]     best_r, best_nxt;
  logic [SUM_W-1:0]  bestd_r, bestd_nxt;
  logic              over_r, over_nxt;
  logic              upd_r, upd_nxt;
  logic [CNTW-1:0]   pass_r, pass_nxt;
  logic [CNTW-1:0]   n_r, n_nxt;
  logic [CNTW-1:0]   rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [STW-1:0]    step_r, step_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        class_r, class_nxt;
  logic [SUM_W-1:0]  dist_r, dist_nxt;
  logic              done_r, done_nxt;
  logic              ovf_r, ovf_nxt;

  // RAM ports
  logic              cen_we;
  logic [NW-1:0]     cen_waddr, cen_raddr;
  logic [FEAT_W-1:0] cen_wdata, cen_rdata;
  logic              sum_we;
  logic [NW-1:0]     sum_waddr, sum_raddr;
  logic [SUM_W-1:0]  sum_wdata, sum_rdata;
  logic              vb_we;
  logic [DW-1:0]     vb_waddr, vb_raddr;
  logic [FEAT_W-1:0] vb_wdata, vb_rdata;
  logic              pd_we;
  logic [KW-1:0]     pd_waddr, pd_raddr;
  logic [SUM_W-1:0]  pd_wdata, pd_rdata;
  logic              cnt_we;
  logic [KW-1:0]     cnt_waddr, cnt_raddr;
  logic [CNTW-1:0]   cnt_wdata, cnt_rdata;

  logic              accept;
  logic              c_last, d_last, e_last;
  logic [FEAT_W-1:0] absd;
  logic [SUM_W:0]    dsum;
  logic [SUM_W-1:0]  dsat;
  logic [SUM_W:0]    asum;
  logic [CNTW:0]     trial;
  logic              load_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign c_last   = (c_r == KW'(CLUSTERS - 1));
  assign d_last   = (d_r == DW'(DIM - 1));
  assign e_last   = (e_r == DW'(DIM - 1));
  assign load_ok  = (32'(in_cluster_index) < CLUSTERS) && (32'(in_dim_index) < DIM);

  // shared arithmetic
  assign absd  = (val_r >= cen_rdata) ? (val_r - cen_rdata) : (cen_rdata - val_r);
  assign dsum  = ((e_r == '0) ? {(SUM_W+1){1'b0}} : {1'b0, pd_rdata}) + (SUM_W+1)'(sq_r);
  assign dsat  = dsum[SUM_W] ? SAT : dsum[SUM_W-1:0];
  assign asum  = {1'b0, sum_rdata} + (SUM_W+1)'(vb_rdata);
  assign trial = {rem_r, quo_r[SUM_W-1]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (addr_r == NW'(N - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_VECTOR) state_nxt = ST_V_RD;
          else if (in_kind == KIND_UPDATE) state_nxt = ST_U_CNT;
        end
      end
      ST_V_RD:  state_nxt = ST_V_SQ;
      ST_V_SQ:  state_nxt = ST_V_ACC;
      ST_V_ACC: begin
        if (!c_last) state_nxt = ST_V_RD;
        else if (!e_last) state_nxt = ST_IDLE;
        else if (32'(pass_r) >= MAX_VECTORS) state_nxt = ST_EMIT;
        else state_nxt = ST_A_RD;
      end
      ST_A_RD:  state_nxt = ST_A_ADD;
      ST_A_ADD: state_nxt = d_last ? ST_C_RD : ST_A_RD;
      ST_C_RD:  state_nxt = ST_C_WR;
      ST_C_WR:  state_nxt = ST_EMIT;
      ST_U_CNT: state_nxt = ST_U_N;
      ST_U_N:   state_nxt = ST_U_RD;
      ST_U_RD:  state_nxt = ST_U_LD;
      ST_U_LD:  state_nxt = (n_r == '0) ? ST_U_WR : ST_U_DIV;
      ST_U_DIV: if (step_r == STW'(DIV_STEPS - 1)) state_nxt = ST_U_WR;
      ST_U_WR: begin
        if (!d_last) state_nxt = ST_U_RD;
        else if (!c_last) state_nxt = ST_U_CNT;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    e_nxt = e_r; d_nxt = d_r; c_nxt = c_r; addr_nxt = addr_r; base_nxt = base_r;
    val_nxt = val_r; sq_nxt = sq_r; best_nxt = best_r; bestd_nxt = bestd_r;
    over_nxt = over_r; upd_nxt = upd_r; pass_nxt = pass_r; n_nxt = n_r;
    rem_nxt = rem_r; quo_nxt = quo_r; step_nxt = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    class_nxt = class_r; dist_nxt = dist_r; done_nxt = done_r; ovf_nxt = ovf_r;

    cen_we = 1'b0; cen_waddr = addr_r; cen_wdata = '0; cen_raddr = addr_r;
    sum_we = 1'b0; sum_waddr = addr_r; sum_wdata = '0; sum_raddr = addr_r;
    vb_we = 1'b0; vb_waddr = e_r; vb_wdata = in_value; vb_raddr = d_r;
    pd_we = 1'b0; pd_waddr = c_r; pd_wdata = dsat; pd_raddr = c_r;
    cnt_we = 1'b0; cnt_waddr = c_r; cnt_wdata = '0; cnt_raddr = c_r;

    case (state_r)
      ST_CLEAR: begin
        sum_we = 1'b1;
        cnt_we = (32'(addr_r) < CLUSTERS);
        cnt_waddr = KW'(addr_r);
        addr_nxt = addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cen_we = load_ok;
            cen_waddr = NW'(32'(in_cluster_index) * DIM + 32'(in_dim_index));
            cen_wdata = in_value;
          end else if (in_kind == KIND_VECTOR) begin
            vb_we = 1'b1;
            val_nxt = in_value;
            c_nxt = '0;
            addr_nxt = NW'(e_r);
          end else if (in_kind == KIND_UPDATE) begin
            c_nxt = '0;
            addr_nxt = '0;
            e_nxt = '0;
            pass_nxt = '0;
          end
        end
      end
      ST_V_SQ: sq_nxt = SQ_W'(absd * absd);
      ST_V_ACC: begin
        pd_we = 1'b1;
        if (c_r == '0 || dsat < bestd_r) begin
          best_nxt = c_r;
          bestd_nxt = dsat;
          base_nxt = addr_r - NW'(e_r);
        end
        if (!c_last) begin
          c_nxt = c_r + 1'b1;
          addr_nxt = addr_r + NW'(DIM);
        end else if (!e_last) begin
          e_nxt = e_r + 1'b1;
        end else begin
          e_nxt = '0;
          upd_nxt = 1'b0;
          over_nxt = (32'(pass_r) >= MAX_VECTORS);
          d_nxt = '0;
          addr_nxt = (c_r == '0 || dsat < bestd_r) ? (addr_r - NW'(e_r)) : base_r;
        end
      end
      ST_A_ADD: begin
        sum_we = 1'b1;
        sum_wdata = asum[SUM_W] ? SAT : asum[SUM_W-1:0];
        d_nxt = d_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      ST_C_RD: cnt_raddr = best_r;
      ST_C_WR: begin
        cnt_we = 1'b1;
        cnt_waddr = best_r;
        cnt_wdata = cnt_rdata + 1'b1;
        pass_nxt = pass_r + 1'b1;
      end
      ST_U_N: begin
        n_nxt = cnt_rdata;
        d_nxt = '0;
      end
      ST_U_LD: begin
        rem_nxt = '0;
        step_nxt = '0;
        quo_nxt = (n_r == '0) ? '0 : sum_rdata;
      end
      ST_U_DIV: begin
        step_nxt = step_r + 1'b1;
        if (trial >= {1'b0, n_r}) begin
          rem_nxt = CNTW'(trial - {1'b0, n_r});
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = CNTW'(trial);
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
      end
      ST_U_WR: begin
        cen_we = 1'b1;
        cen_wdata = (quo_r > SUM_W'(16'hFFFF)) ? 16'hFFFF : quo_r[FEAT_W-1:0];
        sum_we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        d_nxt = d_r + 1'b1;
        if (d_last) begin
          cnt_we = 1'b1;
          c_nxt = c_r + 1'b1;
          if (c_last) begin
            upd_nxt = 1'b1;
            best_nxt = '0;
            bestd_nxt = '0;
            over_nxt = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          class_nxt = 4'(best_r);
          dist_nxt = bestd_r;
          done_nxt = upd_r;
          ovf_nxt = over_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r <= '0;
      e_r <= '0;
      pass_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      e_r <= e_nxt;
      pass_r <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt; c_r <= c_nxt; base_r <= base_nxt; val_r <= val_nxt;
    sq_r <= sq_nxt; best_r <= best_nxt; bestd_r <= bestd_nxt;
    over_r <= over_nxt; upd_r <= upd_nxt; n_r <= n_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; step_r <= step_nxt;
    class_r <= class_nxt; dist_r <= dist_nxt; done_r <= done_nxt; ovf_r <= ovf_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_class_index     = class_r;
  assign out_min_sq_distance = dist_r;
  assign out_update_done     = done_r;
  assign out_pass_overflow   = ovf_r;

  kmau_ram #(.WIDTH(FEAT_W), .DEPTH(N)) u_center (
    .clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
    .raddr(cen_raddr), .rdata(cen_rdata)
  );

  kmau_ram #(.WIDTH(SUM_W), .DEPTH(N)) u_sums (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  kmau_ram #(.WIDTH(FEAT_W), .DEPTH(DIM)) u_vbuf (
    .clk(clk), .we(vb_we), .waddr(vb_waddr), .wdata(vb_wdata),
    .raddr(vb_raddr), .rdata(vb_rdata)
  );

  kmau_ram #(.WIDTH(SUM_W), .DEPTH(CLUSTERS)) u_partial (
    .clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
    .raddr(pd_raddr), .rdata(pd_rdata)
  );

  kmau_ram #(.WIDTH(CNTW), .DEPTH(CLUSTERS)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

endmodule

[sv/kmau_checker.sv]
// ----------------------------------------------------------------------------
// kmau_checker
// Port-level checks for the k-means core, bound to the top level.
// ----------------------------------------------------------------------------
module kmau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_class_index,
  input logic [35:0] out_min_sq_distance,
  input logic        out_update_done,
  input logic        out_pass_overflow
);
  import kmau_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  a_upd_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_update_done |-> out_class_index == 4'd0 &&
      out_min_sq_distance == 36'd0 && !out_pass_overflow)
    else $error("update result carries vector fields");

  // an update sweep keeps the input channel busy right after its word is accepted
  a_upd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_UPDATE |=> !in_ready)
    else $error("ready right after update word");

  a_vec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_VECTOR |=> !in_ready)
    else $error("ready right after vector word");

endmodule

bind kmeans_assign_and_update_core kmau_checker u_kmau_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready),
  .out_class_index(out_class_index), .out_min_sq_distance(out_min_sq_distance),
  .out_update_done(out_update_done), .out_pass_overflow(out_pass_overflow)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k-means assign/update core testbench
// Drives load, vector, update and ignored words through the valid/ready input
// channel. An in-bench predictor works out each nearest-center result and each
// update acknowledgment, and a checker compares every output word with it.
// ----------------------------------------------------------------------------
module testbench;
  import kmau_pkg::*;

  localparam int NDIM = 16;
  localparam int NCL  = 16;
  localparam int MAXV = 1048576;
  localparam logic [35:0] SAT = 36'hF_FFFF_FFFF;
  localparam longint LIMIT = 64'd2_000_000;

  typedef struct packed {
    logic [3:0]  class_index;
    logic [35:0] sq_dist;
    logic        done;
    logic        over;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_NONE;
  logic [3:0]  in_cluster_index = '0;
  logic [3:0]  in_dim_index = '0;
  logic [15:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_class_index;
  logic [35:0] out_min_sq_distance;
  logic        out_update_done;
  logic        out_pass_overflow;

  kmeans_assign_and_update_core u_top (.*);

  // predictor state
  logic [15:0] centers [NCL][NDIM];
  logic [15:0] vec_elems [NDIM];
  logic [35:0] part_dist [NCL];
  logic [35:0] sums [NCL][NDIM];
  logic [20:0] counts [NCL];
  int          elem_cnt;
  int          pass_cnt;
  result_t     expected_q[$];

  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  longint cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [35:0] sat_add(logic [35:0] a, logic [35:0] b);
    logic [36:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[36] ? SAT : s[35:0];
  endfunction

  task automatic predict_word(logic [1:0] kind, logic [3:0] ci, logic [3:0] di,
                              logic [15:0] v);
    int best;
    logic [35:0] bestd;
    longint diff;
    logic [63:0] mean;
    result_t r;
    bit over;
    case (kind)
      KIND_LOAD: centers[ci][di] = v;
      KIND_VECTOR: begin
        vec_elems[elem_cnt] = v;
        for (int c = 0; c < NCL; c++) begin
          diff = longint'(v) - longint'(centers[c][elem_cnt]);
          part_dist[c] = sat_add(part_dist[c], 36'(diff * diff));
        end
        elem_cnt++;
        if (elem_cnt == NDIM) begin
          best = 0;
          bestd = part_dist[0];
          for (int c = 1; c < NCL; c++)
            if (part_dist[c] < bestd) begin
              bestd = part_dist[c];
              best = c;
            end
          over = pass_cnt >= MAXV;
          if (!over) begin
            for (int d = 0; d < NDIM; d++)
              sums[best][d] = sat_add(sums[best][d], 36'(vec_elems[d]));
            counts[best]++;
            pass_cnt++;
          end
          r = '{class_index: 4'(best), sq_dist: bestd, done: 1'b0, over: over};
          expected_q.push_back(r);
          elem_cnt = 0;
          foreach (part_dist[c]) part_dist[c] = '0;
        end
      end
      KIND_UPDATE: begin
        for (int c = 0; c < NCL; c++)
          for (int d = 0; d < NDIM; d++) begin
            mean = 0;
            if (counts[c] != 0) begin
              mean = 64'(sums[c][d]) / 64'(counts[c]);
              if (mean > 64'hFFFF) mean = 64'hFFFF;
            end
            centers[c][d] = mean[15:0];
            sums[c][d] = '0;
          end
        foreach (counts[c]) counts[c] = '0;
        pass_cnt = 0;
        elem_cnt = 0;
        foreach (part_dist[c]) part_dist[c] = '0;
        r = '{class_index: 4'd0, sq_dist: 36'd0, done: 1'b1, over: 1'b0};
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // valid stays up after an accept; the next word, an idle cycle or
  // release_input() takes it down
  task automatic send_word(logic [1:0] kind, logic [3:0] ci, logic [3:0] di,
                           logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_cluster_index <= ci;
    in_dim_index <= di;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(kind, ci, di, v);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // all centers are written once so no never-loaded entry is read
  task automatic load_all(bit extremes);
    for (int c = 0; c < NCL; c++)
      for (int d = 0; d < NDIM; d++)
        send_word(KIND_LOAD, 4'(c), 4'(d),
                  extremes ? ((c % 2) ? 16'hFFFF : 16'h0000) : 16'($urandom));
  endtask

  task automatic send_vector(int style);
    logic [15:0] base;
    base = 16'($urandom);
    for (int d = 0; d < NDIM; d++)
      case (style)
        0: send_word(KIND_VECTOR, 4'($urandom), 4'($urandom), 16'($urandom));
        1: send_word(KIND_VECTOR, 4'd0, 4'd0, 16'hFFFF);
        2: send_word(KIND_VECTOR, 4'd0, 4'd0, 16'h0000);
        default: send_word(KIND_VECTOR, 4'($urandom), 4'($urandom),
                           base + 16'($urandom_range(1023)) - 16'd512);
      endcase
  endtask

  task automatic drain();
    release_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic test_directed();
    load_all(1'b1);
    send_vector(1);
    send_vector(2);
    // ignored kind with all-ones fields
    send_word(KIND_NONE, 4'hF, 4'hF, 16'hFFFF);
    // reload mid-vector and update mid-vector
    for (int d = 0; d < 5; d++) send_word(KIND_VECTOR, 4'h0, 4'h0, 16'h8000);
    send_word(KIND_LOAD, 4'd3, 4'd7, 16'h1234);
    send_word(KIND_VECTOR, 4'h0, 4'h0, 16'h1234);
    send_word(KIND_UPDATE, 4'hF, 4'hF, 16'hFFFF);
    // update with all clusters empty clears every center
    send_word(KIND_UPDATE, 4'h0, 4'h0, 16'h0000);
    send_vector(1);
    drain();
  endtask

  task automatic test_random(int vectors);
    int pick;
    load_all(1'b0);
    for (int n = 0; n < vectors; n++) begin
      pick = $urandom_range(99);
      if (pick < 80) send_vector(pick < 40 ? 3 : 0);
      else if (pick < 88)
        send_word(KIND_LOAD, 4'($urandom), 4'($urandom), 16'($urandom));
      else if (pick < 92)
        send_word(KIND_NONE, 4'($urandom), 4'($urandom), 16'($urandom));
      else if (pick < 95)
        for (int d = $urandom_range(1, NDIM - 1); d > 0; d--)
          send_word(KIND_VECTOR, 4'($urandom), 4'($urandom), 16'($urandom));
      else send_word(KIND_UPDATE, 4'($urandom), 4'($urandom), 16'($urandom));
    end
    send_word(KIND_UPDATE, 4'd0, 4'd0, 16'd0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    send_vector(3);
    send_vector(3);
    send_vector(0);
    release_input();
    wait (!hold_off);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    @(posedge clk);
    wait (hold_off);
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_class_index), 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (out_class_index !== e.class_index)
          report_mismatch("class_index", 64'(out_class_index), 64'(e.class_index));
        if (out_min_sq_distance !== e.sq_dist)
          report_mismatch("min_sq_distance", 64'(out_min_sq_distance), 64'(e.sq_dist));
        if (out_update_done !== e.done)
          report_mismatch("update_done", 64'(out_update_done), 64'(e.done));
        if (out_pass_overflow !== e.over)
          report_mismatch("pass_overflow", 64'(out_pass_overflow), 64'(e.over));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    foreach (part_dist[c]) begin
      part_dist[c] = '0;
      counts[c] = '0;
      for (int d = 0; d < NDIM; d++) begin
        centers[c][d] = '0;
        sums[c][d] = '0;
      end
    end
    elem_cnt = 0;
    pass_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(10);
    send_idle_pct = 72;
    test_random(7);
    send_idle_pct = 0;
    recv_stall_pct = 72;
    test_random(7);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    test_random(7);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    if (expected_q.size() != 0) begin
      report_mismatch("words left over", 64'(expected_q.size()), 64'd0);
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
